// ===== rtl/abr_pkg.sv =====
package abr_pkg;

	localparam int RATE_W = 30;
	localparam int TIME_W = 32;
	localparam int HELD_W = 15;

	localparam logic [1:0] MODE_NET   = 2'd0;
	localparam logic [1:0] MODE_LOCAL = 2'd1;
	localparam logic [1:0] MODE_TAKE  = 2'd2;

	localparam logic [2:0] REASON_DROP     = 3'd0;
	localparam logic [2:0] REASON_QDELAY   = 3'd1;
	localparam logic [2:0] REASON_INTERVAL = 3'd2;
	localparam logic [2:0] REASON_SEVERE   = 3'd3;
	localparam logic [2:0] REASON_MODERATE = 3'd4;
	localparam logic [2:0] REASON_CLEAN    = 3'd5;

	localparam logic [2:0] IV_SHORT = 3'd2;
	localparam logic [2:0] IV_MID   = 3'd3;
	localparam logic [2:0] IV_LONG  = 3'd5;

	localparam logic [RATE_W-1:0] RESET_MAX_RATE = 30'd20000000;
	localparam logic [RATE_W-1:0] ABS_MIN_RATE   = 30'd2000000;
	localparam logic [RATE_W-1:0] RATE_IV_LONG   = 30'd6000000;
	localparam logic [RATE_W-1:0] RATE_IV_MID    = 30'd10000000;
	localparam logic [30:0]       MIN_STEP       = 31'd500000;

	localparam logic [15:0] LOSS_SEVERE   = 16'd3277;
	localparam logic [15:0] LOSS_MODERATE = 16'd1311;
	localparam logic [15:0] NACK_LIMIT    = 16'd8;
	localparam logic [16:0] RTT_MARGIN    = 17'd20;
	localparam logic [HELD_W-1:0] QDELAY_LONG = 15'd1600;
	localparam logic [HELD_W-1:0] LATE_LONG   = 15'd64;
	localparam logic [HELD_W-1:0] LATE_MID    = 15'd32;
	localparam logic [TIME_W-1:0] COOLDOWN_MS = 32'd1000;
	localparam logic [TIME_W-1:0] RAISE_WAIT_MS = 32'd3000;

	localparam logic [1:0] REFRESH_CYCLES = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] now_ms;
		logic        rtt_present;
		logic [15:0] rtt_ms;
		logic [15:0] loss_q16;
		logic [15:0] nack_count;
		logic        rr_present;
		logic signed [15:0] queue_delay;
		logic signed [15:0] sched_lateness;
		logic [31:0] dropped_total;
	} item_t;

	typedef struct packed {
		logic              decision_present;
		logic [RATE_W-1:0] media_bitrate;
		logic [30:0]       pacing_bitrate;
		logic [2:0]        pacing_interval_ms;
		logic              key_frame_req;
		logic [2:0]        reason_code;
	} result_t;

	function automatic logic [HELD_W-1:0] held_q4(input logic signed [15:0] raw);
		held_q4 = raw[15] ? '0 : raw[HELD_W-1:0];
	endfunction

	function automatic logic [2:0] interval_sel(input logic [HELD_W-1:0] late,
			input logic [RATE_W-1:0] rate);
		if (late >= LATE_LONG && rate <= RATE_IV_LONG)
			interval_sel = IV_LONG;
		else if (late >= LATE_MID && rate <= RATE_IV_MID)
			interval_sel = IV_MID;
		else
			interval_sel = IV_SHORT;
	endfunction

endpackage

// ===== rtl/abr_if.sv =====
interface abr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] now_ms;
	logic        rtt_present;
	logic [15:0] rtt_ms;
	logic [15:0] loss_q16;
	logic [15:0] nack_count;
	logic        rr_present;
	logic signed [15:0] queue_delay;
	logic signed [15:0] sched_lateness;
	logic [31:0] dropped_total;

	modport source (output valid, mode, now_ms, rtt_present, rtt_ms, loss_q16,
		nack_count, rr_present, queue_delay, sched_lateness, dropped_total,
		input ready);
	modport sink (input valid, mode, now_ms, rtt_present, rtt_ms, loss_q16,
		nack_count, rr_present, queue_delay, sched_lateness, dropped_total,
		output ready);
endinterface

interface abr_out_if;
	logic        valid;
	logic        ready;
	logic        decision_present;
	logic [29:0] media_bitrate;
	logic [30:0] pacing_bitrate;
	logic [2:0]  pacing_interval_ms;
	logic        key_frame_req;
	logic [2:0]  reason_code;

	modport source (output valid, decision_present, media_bitrate, pacing_bitrate,
		pacing_interval_ms, key_frame_req, reason_code, input ready);
	modport sink (input valid, decision_present, media_bitrate, pacing_bitrate,
		pacing_interval_ms, key_frame_req, reason_code, output ready);
endinterface

// ===== rtl/abr_div20.sv =====
module abr_div20 (
	input  logic        clk,
	input  logic [34:0] x,
	output logic [30:0] q
);

	logic [32:0] y;
	logic [16:0] a;
	logic [15:0] b;
	logic [17:0] s;
	logic [35:0] prod_s;
	logic [30:0] prod_a_s2;
	logic [15:0] prod_s_s2;

	// x/20 = (x/4)/5; with y = a*65536 + b, y/5 = a*13107 + (a + b)/5
	assign y      = x[34:2];
	assign a      = y[32:16];
	assign b      = y[15:0];
	assign s      = {1'b0, a} + {2'b0, b};
	assign prod_s = {18'b0, s} * 36'd209716;

	always_ff @(posedge clk) begin
		prod_a_s2 <= {14'b0, a} * 31'd13107;
		prod_s_s2 <= prod_s[35:20];
	end

	assign q = prod_a_s2 + {15'b0, prod_s_s2};

endmodule

// ===== rtl/abr_scale.sv =====
module abr_scale (
	input  logic                       clk,
	input  logic [abr_pkg::RATE_W-1:0] rate,
	input  logic [abr_pkg::RATE_W-1:0] max_rate,
	output logic [abr_pkg::RATE_W-1:0] dec85,
	output logic [abr_pkg::RATE_W-1:0] dec90,
	output logic [abr_pkg::RATE_W-1:0] inc_rate
);

	logic [34:0] x85_s1;
	logic [34:0] x90_s1;
	logic [34:0] x5_s1;
	logic [abr_pkg::RATE_W-1:0] rate_s1;
	logic [abr_pkg::RATE_W-1:0] max_s1;
	logic [abr_pkg::RATE_W-1:0] rate_s2;
	logic [abr_pkg::RATE_W-1:0] max_s2;
	logic [30:0] q85;
	logic [30:0] q90;
	logic [30:0] q5;
	logic [30:0] step;
	logic [30:0] sum;
	logic [abr_pkg::RATE_W-1:0] dec85_s3;
	logic [abr_pkg::RATE_W-1:0] dec90_s3;
	logic [abr_pkg::RATE_W-1:0] inc_s3;

	// round-half-up: r*85/100 -> (17r+10)/20, r*90/100 -> (18r+10)/20, r*5/100 -> (r+10)/20
	always_ff @(posedge clk) begin
		x85_s1  <= {1'b0, rate, 4'b0} + {5'b0, rate} + 35'd10;
		x90_s1  <= {1'b0, rate, 4'b0} + {4'b0, rate, 1'b0} + 35'd10;
		x5_s1   <= {5'b0, rate} + 35'd10;
		rate_s1 <= rate;
		max_s1  <= max_rate;
		rate_s2 <= rate_s1;
		max_s2  <= max_s1;
	end

	abr_div20 u_div85 (.clk(clk), .x(x85_s1), .q(q85));
	abr_div20 u_div90 (.clk(clk), .x(x90_s1), .q(q90));
	abr_div20 u_div5  (.clk(clk), .x(x5_s1),  .q(q5));

	assign step = (q5 < abr_pkg::MIN_STEP) ? abr_pkg::MIN_STEP : q5;
	assign sum  = {1'b0, rate_s2} + step;

	always_ff @(posedge clk) begin
		dec85_s3 <= q85[abr_pkg::RATE_W-1:0];
		dec90_s3 <= q90[abr_pkg::RATE_W-1:0];
		inc_s3   <= (sum > {1'b0, max_s2}) ? max_s2 : sum[abr_pkg::RATE_W-1:0];
	end

	assign dec85    = dec85_s3;
	assign dec90    = dec90_s3;
	assign inc_rate = inc_s3;

endmodule

// ===== rtl/abr_core.sv =====
module abr_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [abr_pkg::RATE_W-1:0] cfg_wdata,
	input  logic                       fire,
	input  abr_pkg::item_t             item,
	output abr_pkg::result_t           result,
	output logic                       busy
);

	logic [abr_pkg::RATE_W-1:0] rate_q;
	logic [abr_pkg::RATE_W-1:0] max_q;
	logic [1:0]  clean_q;
	logic [31:0] last_dec_q;
	logic        dec_ever_q;
	logic [15:0] prev_rtt_q;
	logic        prev_rtt_vld_q;
	logic [31:0] prev_drop_q;
	logic [abr_pkg::HELD_W-1:0] late_q;
	logic        pend_vld_q;
	logic [abr_pkg::RATE_W-1:0] pend_rate_q;
	logic [2:0]  pend_iv_q;
	logic        pend_key_q;
	logic [2:0]  pend_reason_q;
	logic [1:0]  refresh_q;

	logic [abr_pkg::RATE_W-1:0] dec85;
	logic [abr_pkg::RATE_W-1:0] dec90;
	logic [abr_pkg::RATE_W-1:0] inc_rate;
	logic [abr_pkg::RATE_W-1:0] min_rate;
	logic [31:0] dt;
	logic        cool;
	logic        raise_wait;
	logic        growth;
	logic [1:0]  clean_inc;
	logic [abr_pkg::HELD_W-1:0] qd_new;
	logic [abr_pkg::HELD_W-1:0] late_new;

	logic        pub_en;
	logic [abr_pkg::RATE_W-1:0] pub_rate;
	logic        pub_key;
	logic [2:0]  pub_reason;
	logic        mark;
	logic        take_hit;
	logic [1:0]  clean_d;
	logic        rtt_upd;
	logic        local_upd;
	logic        drop_upd;
	logic [abr_pkg::HELD_W-1:0] late_d;
	logic [2:0]  iv_pub;
	logic [abr_pkg::RATE_W-1:0] r_lo;
	logic [abr_pkg::RATE_W-1:0] r_cl;
	logic        pub_write;

	abr_scale u_scale (
		.clk      (clk),
		.rate     (rate_q),
		.max_rate (max_q),
		.dec85    (dec85),
		.dec90    (dec90),
		.inc_rate (inc_rate)
	);

	assign min_rate   = (max_q < abr_pkg::ABS_MIN_RATE) ? max_q : abr_pkg::ABS_MIN_RATE;
	assign dt         = item.now_ms - last_dec_q;
	assign cool       = !dec_ever_q || (dt >= abr_pkg::COOLDOWN_MS);
	assign raise_wait = dec_ever_q && (dt < abr_pkg::RAISE_WAIT_MS);
	assign growth     = item.rtt_present && prev_rtt_vld_q &&
		({1'b0, item.rtt_ms} > ({1'b0, prev_rtt_q} + abr_pkg::RTT_MARGIN)) &&
		({1'b0, item.rtt_ms, 1'b0} > ({2'b0, prev_rtt_q} + {1'b0, prev_rtt_q, 1'b0}));
	assign clean_inc  = (clean_q == 2'd3) ? 2'd3 : clean_q + 2'd1;
	assign qd_new     = abr_pkg::held_q4(item.queue_delay);
	assign late_new   = abr_pkg::held_q4(item.sched_lateness);

	always_comb begin
		pub_en     = 1'b0;
		pub_rate   = rate_q;
		pub_key    = 1'b0;
		pub_reason = abr_pkg::REASON_DROP;
		mark       = 1'b0;
		take_hit   = 1'b0;
		clean_d    = clean_q;
		rtt_upd    = 1'b0;
		local_upd  = 1'b0;
		drop_upd   = 1'b0;
		late_d     = late_q;
		if (fire) begin
			case (item.mode)
				abr_pkg::MODE_NET: begin
					rtt_upd = item.rtt_present;
					if (item.loss_q16 >= abr_pkg::LOSS_SEVERE) begin
						clean_d = 2'd0;
						if (cool) begin
							mark       = 1'b1;
							pub_en     = 1'b1;
							pub_rate   = dec85;
							pub_reason = abr_pkg::REASON_SEVERE;
						end
					end else if (item.loss_q16 >= abr_pkg::LOSS_MODERATE ||
							item.nack_count >= abr_pkg::NACK_LIMIT || growth) begin
						clean_d = 2'd0;
						if (cool) begin
							mark       = 1'b1;
							pub_en     = 1'b1;
							pub_rate   = dec90;
							pub_reason = abr_pkg::REASON_MODERATE;
						end
					end else if (item.rr_present) begin
						if (clean_inc != 2'd3 || rate_q >= max_q || raise_wait) begin
							clean_d = clean_inc;
						end else begin
							clean_d    = 2'd0;
							pub_en     = 1'b1;
							pub_rate   = inc_rate;
							pub_reason = abr_pkg::REASON_CLEAN;
						end
					end
				end
				abr_pkg::MODE_LOCAL: begin
					local_upd = 1'b1;
					late_d    = late_new;
					if (item.dropped_total > prev_drop_q) begin
						drop_upd = 1'b1;
						clean_d  = 2'd0;
						if (cool) begin
							mark       = 1'b1;
							pub_en     = 1'b1;
							pub_rate   = dec85;
							pub_key    = 1'b1;
							pub_reason = abr_pkg::REASON_DROP;
						end
					end else if (qd_new >= abr_pkg::QDELAY_LONG && cool) begin
						clean_d    = 2'd0;
						mark       = 1'b1;
						pub_en     = 1'b1;
						pub_rate   = dec90;
						pub_reason = abr_pkg::REASON_QDELAY;
					end else if (abr_pkg::interval_sel(late_new, rate_q) !=
							abr_pkg::interval_sel(late_q, rate_q)) begin
						pub_en     = 1'b1;
						pub_reason = abr_pkg::REASON_INTERVAL;
					end
				end
				abr_pkg::MODE_TAKE: begin
					take_hit = pend_vld_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign iv_pub    = abr_pkg::interval_sel(late_d, rate_q);
	assign r_lo      = (pub_rate < min_rate) ? min_rate : pub_rate;
	assign r_cl      = (r_lo > max_q) ? max_q : r_lo;
	assign pub_write = pub_en &&
		!(r_cl == rate_q && pend_vld_q && pend_iv_q == iv_pub && !pub_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q         <= abr_pkg::RESET_MAX_RATE;
			max_q          <= abr_pkg::RESET_MAX_RATE;
			clean_q        <= 2'd0;
			last_dec_q     <= '0;
			dec_ever_q     <= 1'b0;
			prev_rtt_q     <= '0;
			prev_rtt_vld_q <= 1'b0;
			prev_drop_q    <= '0;
			late_q         <= '0;
			pend_vld_q     <= 1'b0;
			pend_rate_q    <= '0;
			pend_iv_q      <= abr_pkg::IV_SHORT;
			pend_key_q     <= 1'b0;
			pend_reason_q  <= abr_pkg::REASON_DROP;
			refresh_q      <= abr_pkg::REFRESH_CYCLES;
		end else begin
			clean_q <= clean_d;
			if (mark) begin
				last_dec_q <= item.now_ms;
				dec_ever_q <= 1'b1;
			end
			if (rtt_upd) begin
				prev_rtt_q     <= item.rtt_ms;
				prev_rtt_vld_q <= 1'b1;
			end
			if (drop_upd)
				prev_drop_q <= item.dropped_total;
			if (local_upd)
				late_q <= late_new;
			if (take_hit)
				pend_vld_q <= 1'b0;
			if (pub_write) begin
				pend_vld_q    <= 1'b1;
				pend_rate_q   <= r_cl;
				pend_iv_q     <= iv_pub;
				pend_key_q    <= pub_key;
				pend_reason_q <= pub_reason;
			end
			// hold items until the scaled rates follow the new rate
			if (cfg_we) begin
				max_q     <= cfg_wdata;
				rate_q    <= cfg_wdata;
				refresh_q <= abr_pkg::REFRESH_CYCLES;
			end else if (pub_write) begin
				rate_q    <= r_cl;
				refresh_q <= abr_pkg::REFRESH_CYCLES;
			end else if (refresh_q != 2'd0) begin
				refresh_q <= refresh_q - 2'd1;
			end
		end
	end

	assign busy = (refresh_q != 2'd0);

	always_comb begin
		result                    = '0;
		result.pacing_interval_ms = abr_pkg::IV_SHORT;
		if (take_hit) begin
			result.decision_present   = 1'b1;
			result.media_bitrate      = pend_rate_q;
			result.pacing_bitrate     = {pend_rate_q, 1'b0};
			result.pacing_interval_ms = pend_iv_q;
			result.key_frame_req      = pend_key_q;
			result.reason_code        = pend_reason_q;
		end
	end

endmodule

// ===== rtl/adaptive_bitrate_controller_top.sv =====
// An accepted item waits in the input register; when not held it fires and its result is registered.
// Throughput: one item per cycle unless held or stalled; after an item that publishes a decision,
// or a max_bitrate write, items are held while the pipelined x0.85 / x0.90 / +5% rate scalers refresh.
// A waiting result stalls the input only once the input register also holds an item.
// Reset (arst_n low, asynchronous): rate and max_bitrate at 20 Mbps, no pending decision,
// pending interval 2 ms; items are held after reset until the rate scalers have refreshed.
module adaptive_bitrate_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        max_bitrate_we,
	input  logic [29:0] max_bitrate_wdata,
	abr_in_if.sink      report,
	abr_out_if.source   decision
);

	logic              s1_vld_q;
	abr_pkg::item_t    item_s1;
	logic              out_vld_q;
	abr_pkg::result_t  result_q;
	abr_pkg::result_t  result;
	logic              busy;
	logic              fire;
	logic              in_take;

	assign fire    = s1_vld_q && !busy && (!out_vld_q || decision.ready);
	assign in_take = report.valid && report.ready;
	assign report.ready = !s1_vld_q || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_take)
				s1_vld_q <= 1'b1;
			else if (fire)
				s1_vld_q <= 1'b0;
			if (fire)
				out_vld_q <= 1'b1;
			else if (decision.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.mode           <= report.mode;
			item_s1.now_ms         <= report.now_ms;
			item_s1.rtt_present    <= report.rtt_present;
			item_s1.rtt_ms         <= report.rtt_ms;
			item_s1.loss_q16       <= report.loss_q16;
			item_s1.nack_count     <= report.nack_count;
			item_s1.rr_present     <= report.rr_present;
			item_s1.queue_delay    <= report.queue_delay;
			item_s1.sched_lateness <= report.sched_lateness;
			item_s1.dropped_total  <= report.dropped_total;
		end
		if (fire)
			result_q <= result;
	end

	abr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (max_bitrate_we),
		.cfg_wdata (max_bitrate_wdata),
		.fire      (fire),
		.item      (item_s1),
		.result    (result),
		.busy      (busy)
	);

	assign decision.valid              = out_vld_q;
	assign decision.decision_present   = result_q.decision_present;
	assign decision.media_bitrate      = result_q.media_bitrate;
	assign decision.pacing_bitrate     = result_q.pacing_bitrate;
	assign decision.pacing_interval_ms = result_q.pacing_interval_ms;
	assign decision.key_frame_req      = result_q.key_frame_req;
	assign decision.reason_code        = result_q.reason_code;

endmodule

// ===== dv/abr_decision_checker.sv =====
`timescale 1ns / 1ps
module abr_decision_checker
	import abr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        max_bitrate_we,
	input  logic [29:0] max_bitrate_wdata,
	abr_in_if           report,
	abr_out_if          decision,
	output int          mismatches,
	output int          decisions_owed
);

	localparam bit [31:0] CUT_HARD_PCT = 32'd85;
	localparam bit [31:0] CUT_SOFT_PCT = 32'd90;
	localparam bit [31:0] RAISE_PCT    = 32'd5;

	bit [31:0] rate_cap;
	bit [31:0] rate_now;
	bit [1:0]  clean_run;
	bit [31:0] last_cut_ms;
	bit        cut_seen;
	bit [15:0] rtt_last;
	bit        rtt_last_ok;
	bit [31:0] drops_seen;
	bit [14:0] qdelay_q4;
	bit [14:0] late_q4;
	bit        dec_valid;
	bit [31:0] dec_rate;
	bit [2:0]  dec_iv;
	bit        dec_key;
	bit [2:0]  dec_reason;

	result_t decisions_due[$];
	item_t   seen_item;
	result_t seen_result;
	result_t due_result;

	function automatic bit [31:0] scaled(input bit [31:0] r, input bit [31:0] pct);
		bit [63:0] prod;
		prod = 64'(r) * 64'(pct) + 64'd50;
		return 32'(prod / 64'd100);
	endfunction

	function automatic bit [2:0] interval_for_state();
		if (late_q4 >= LATE_LONG && rate_now <= 32'(RATE_IV_LONG))
			return IV_LONG;
		if (late_q4 >= LATE_MID && rate_now <= 32'(RATE_IV_MID))
			return IV_MID;
		return IV_SHORT;
	endfunction

	function automatic bit cooled(input bit [31:0] t);
		bit [31:0] gap;
		gap = t - last_cut_ms;
		return !cut_seen || gap >= COOLDOWN_MS;
	endfunction

	task automatic note_cut(input bit [31:0] t);
		last_cut_ms = t;
		cut_seen = 1'b1;
	endtask

	task automatic set_decision(input bit [31:0] r, input bit key, input bit [2:0] why);
		bit [31:0] lo;
		bit [2:0]  iv;
		lo = (rate_cap < 32'(ABS_MIN_RATE)) ? rate_cap : 32'(ABS_MIN_RATE);
		if (r < lo)
			r = lo;
		if (r > rate_cap)
			r = rate_cap;
		iv = interval_for_state();
		if (r == rate_now && dec_valid && dec_iv == iv && !key)
			return;
		rate_now = r;
		dec_valid = 1'b1;
		dec_rate = r;
		dec_iv = iv;
		dec_key = key;
		dec_reason = why;
	endtask

	task automatic on_network(input item_t it);
		bit        growth;
		bit [31:0] rtt;
		bit [31:0] bump;
		bit [63:0] total;
		growth = 1'b0;
		rtt = 32'(it.rtt_ms);
		if (it.rtt_present && rtt_last_ok)
			growth = rtt > 32'(rtt_last) + 32'd20 && rtt * 2 > 32'(rtt_last) * 3;
		if (it.rtt_present) begin
			rtt_last = it.rtt_ms;
			rtt_last_ok = 1'b1;
		end
		if (it.loss_q16 >= LOSS_SEVERE) begin
			clean_run = '0;
			if (cooled(it.now_ms)) begin
				note_cut(it.now_ms);
				set_decision(scaled(rate_now, CUT_HARD_PCT), 1'b0, REASON_SEVERE);
			end
			return;
		end
		if (it.loss_q16 >= LOSS_MODERATE || it.nack_count >= NACK_LIMIT || growth) begin
			clean_run = '0;
			if (cooled(it.now_ms)) begin
				note_cut(it.now_ms);
				set_decision(scaled(rate_now, CUT_SOFT_PCT), 1'b0, REASON_MODERATE);
			end
			return;
		end
		if (!it.rr_present)
			return;
		if (clean_run != 2'd3)
			clean_run++;
		if (clean_run != 2'd3 || rate_now >= rate_cap
				|| (cut_seen && 32'(it.now_ms - last_cut_ms) < RAISE_WAIT_MS))
			return;
		clean_run = '0;
		bump = scaled(rate_now, RAISE_PCT);
		if (bump < 32'(MIN_STEP))
			bump = 32'(MIN_STEP);
		total = 64'(rate_now) + 64'(bump);
		if (total > 64'(rate_cap))
			total = 64'(rate_cap);
		set_decision(32'(total), 1'b0, REASON_CLEAN);
	endtask

	task automatic on_pacer(input item_t it);
		bit [2:0] was;
		was = interval_for_state();
		qdelay_q4 = it.queue_delay[15] ? '0 : it.queue_delay[14:0];
		late_q4 = it.sched_lateness[15] ? '0 : it.sched_lateness[14:0];
		if (it.dropped_total > drops_seen) begin
			drops_seen = it.dropped_total;
			clean_run = '0;
			if (cooled(it.now_ms)) begin
				note_cut(it.now_ms);
				set_decision(scaled(rate_now, CUT_HARD_PCT), 1'b1, REASON_DROP);
			end
		end else if (qdelay_q4 >= QDELAY_LONG && cooled(it.now_ms)) begin
			clean_run = '0;
			note_cut(it.now_ms);
			set_decision(scaled(rate_now, CUT_SOFT_PCT), 1'b0, REASON_QDELAY);
		end else if (interval_for_state() != was) begin
			set_decision(rate_now, 1'b0, REASON_INTERVAL);
		end
	endtask

	task automatic advance_controller(input item_t it);
		result_t r;
		r = '0;
		r.pacing_interval_ms = IV_SHORT;
		case (it.mode)
			MODE_NET: on_network(it);
			MODE_LOCAL: on_pacer(it);
			MODE_TAKE: begin
				if (dec_valid) begin
					dec_valid = 1'b0;
					r.decision_present = 1'b1;
					r.media_bitrate = dec_rate[29:0];
					r.pacing_bitrate = {dec_rate[29:0], 1'b0};
					r.pacing_interval_ms = dec_iv;
					r.key_frame_req = dec_key;
					r.reason_code = dec_reason;
				end
			end
			default: ;
		endcase
		decisions_due.push_back(r);
	endtask

	task automatic match(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_cap = 32'(RESET_MAX_RATE);
			rate_now = 32'(RESET_MAX_RATE);
			clean_run = '0;
			last_cut_ms = '0;
			cut_seen = 1'b0;
			rtt_last = '0;
			rtt_last_ok = 1'b0;
			drops_seen = '0;
			qdelay_q4 = '0;
			late_q4 = '0;
			dec_valid = 1'b0;
			dec_rate = '0;
			dec_iv = IV_SHORT;
			dec_key = 1'b0;
			dec_reason = REASON_DROP;
			decisions_due.delete();
			mismatches = 0;
			decisions_owed <= 0;
		end else begin
			if (decision.valid && decision.ready) begin
				seen_result = {decision.decision_present, decision.media_bitrate,
					decision.pacing_bitrate, decision.pacing_interval_ms,
					decision.key_frame_req, decision.reason_code};
				if (decisions_due.size() == 0) begin
					$error("decision item with nothing expected");
					mismatches++;
				end else begin
					due_result = decisions_due.pop_front();
					match("decision_present", due_result.decision_present,
						seen_result.decision_present);
					match("media_bitrate", due_result.media_bitrate,
						seen_result.media_bitrate);
					match("pacing_bitrate", due_result.pacing_bitrate,
						seen_result.pacing_bitrate);
					match("pacing_interval_ms", due_result.pacing_interval_ms,
						seen_result.pacing_interval_ms);
					match("key_frame_req", due_result.key_frame_req,
						seen_result.key_frame_req);
					match("reason_code", due_result.reason_code, seen_result.reason_code);
				end
			end
			if (max_bitrate_we) begin
				rate_cap = 32'(max_bitrate_wdata);
				rate_now = 32'(max_bitrate_wdata);
			end
			if (report.valid && report.ready) begin
				seen_item = {report.mode, report.now_ms, report.rtt_present, report.rtt_ms,
					report.loss_q16, report.nack_count, report.rr_present,
					report.queue_delay, report.sched_lateness, report.dropped_total};
				advance_controller(seen_item);
			end
			decisions_owed <= decisions_due.size();
		end
	end

endmodule

// ===== dv/adaptive_bitrate_controller_top_tb.sv =====
`timescale 1ns / 1ps
module adaptive_bitrate_controller_top_tb;
	import abr_pkg::*;

	localparam logic [1:0] MODE_UNKNOWN = 2'd3;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int CAP_PHASES    = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int LONG_HOLD     = 400;
	localparam int HOLD_AT       = 1100;

	logic        clk;
	logic        arst_n;
	logic        max_bitrate_we;
	logic [29:0] max_bitrate_wdata;
	int          mismatches;
	int          decisions_owed;

	int        send_idle_pct = 20;
	int        recv_idle_pct = 85;
	bit        hold_req = 1'b0;
	bit [31:0] ms_now;
	bit [31:0] drops_base;
	bit [31:0] rtt_base;
	bit        calm;
	int        calm_left;

	abr_in_if  report_if();
	abr_out_if decision_if();

	adaptive_bitrate_controller_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.max_bitrate_we   (max_bitrate_we),
		.max_bitrate_wdata(max_bitrate_wdata),
		.report           (report_if),
		.decision         (decision_if)
	);

	abr_decision_checker decision_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.max_bitrate_we   (max_bitrate_we),
		.max_bitrate_wdata(max_bitrate_wdata),
		.report           (report_if),
		.decision         (decision_if),
		.mismatches       (mismatches),
		.decisions_owed   (decisions_owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		decision_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				decision_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end
			decision_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic put_fields(input item_t it);
		{report_if.mode, report_if.now_ms, report_if.rtt_present, report_if.rtt_ms,
			report_if.loss_q16, report_if.nack_count, report_if.rr_present,
			report_if.queue_delay, report_if.sched_lateness, report_if.dropped_total} <= it;
	endtask

	task automatic offer(input item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			report_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		report_if.valid <= 1'b1;
		put_fields(it);
		@(posedge clk);
		while (!report_if.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		report_if.valid <= 1'b0;
		@(posedge clk);
		while (decisions_owed != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_max_rate(input logic [29:0] cap);
		drain();
		max_bitrate_we <= 1'b1;
		max_bitrate_wdata <= cap;
		@(posedge clk);
		max_bitrate_we <= 1'b0;
	endtask

	function automatic item_t blank(input logic [1:0] m, input logic [31:0] t);
		item_t it;
		it = '0;
		it.mode = m;
		it.now_ms = t;
		return it;
	endfunction

	task automatic roll_report(input int idx, output item_t it);
		int p;
		p = $urandom_range(99);
		if (p < 2)
			ms_now = $urandom;
		else if (p < 12)
			ms_now += $urandom_range(1000, 4000);
		else
			ms_now += $urandom_range(0, 800);
		it.now_ms = ms_now;
		it.mode = 2'($urandom_range(3));
		it.rtt_present = 1'($urandom_range(1));
		it.rtt_ms = 16'($urandom);
		it.loss_q16 = 16'($urandom);
		it.nack_count = 16'($urandom);
		it.rr_present = 1'($urandom_range(1));
		it.queue_delay = 16'($urandom);
		it.sched_lateness = 16'($urandom);
		it.dropped_total = drops_base;
		if (idx >= RANDOM_ITEMS - 40 && $urandom_range(3) == 0)
			it.dropped_total = $urandom;
		if ($urandom_range(99) < 8)
			return;

		if (calm_left == 0) begin
			calm = !calm;
			calm_left = calm ? $urandom_range(8, 30) : $urandom_range(2, 8);
			if ($urandom_range(3) == 0)
				rtt_base = $urandom_range(20, 300);
		end
		calm_left--;

		p = $urandom_range(99);
		if (p < 42) begin
			it.mode = MODE_NET;
			it.rtt_present = ($urandom_range(99) < 85);
			it.rtt_ms = 16'(rtt_base + $urandom_range(0, 10));
			it.loss_q16 = 16'($urandom_range(0, 1000));
			it.nack_count = 16'($urandom_range(0, 7));
			it.rr_present = ($urandom_range(99) < 90);
			if (!calm) begin
				case ($urandom_range(5))
					0: it.loss_q16 = 16'($urandom_range(LOSS_SEVERE, 16'hFFFF));
					1: it.loss_q16 = 16'($urandom_range(LOSS_MODERATE, LOSS_SEVERE - 1));
					2: it.nack_count = 16'($urandom_range(NACK_LIMIT, 60));
					3: it.rtt_ms = 16'(rtt_base * 2 + 25);
					4: begin
						case ($urandom_range(3))
							0: it.loss_q16 = LOSS_MODERATE - 16'd1;
							1: it.loss_q16 = LOSS_MODERATE;
							2: it.loss_q16 = LOSS_SEVERE - 16'd1;
							default: it.loss_q16 = LOSS_SEVERE;
						endcase
					end
					default: ;
				endcase
			end
		end else if (p < 72) begin
			it.mode = MODE_LOCAL;
			it.queue_delay = 16'($urandom_range(0, 1500));
			p = $urandom_range(99);
			if (p < 35)
				it.sched_lateness = 16'($urandom_range(0, 31));
			else if (p < 60)
				it.sched_lateness = 16'($urandom_range(32, 63));
			else if (p < 85)
				it.sched_lateness = 16'($urandom_range(64, 300));
			else if (p < 95)
				it.sched_lateness = {1'b1, 15'($urandom)};
			if (!calm) begin
				case ($urandom_range(4))
					0: begin
						drops_base += $urandom_range(1, 5);
						it.dropped_total = drops_base;
					end
					1: it.queue_delay = 16'($urandom_range(QDELAY_LONG, 16'h7FFF));
					2: it.queue_delay = {1'b1, 15'($urandom)};
					3: it.dropped_total = drops_base - $urandom_range(1, 3);
					default: ;
				endcase
			end
		end else begin
			it.mode = MODE_TAKE;
		end
	endtask

	initial begin
		item_t       it;
		logic [29:0] cap;
		int          idx;

		arst_n <= 1'b0;
		max_bitrate_we <= 1'b0;
		max_bitrate_wdata <= '0;
		report_if.valid <= 1'b0;
		put_fields('0);
		calm = 1'b0;
		calm_left = 0;
		rtt_base = 32'd60;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		it = blank(MODE_TAKE, 32'd0);
		offer(it);
		it = blank(MODE_UNKNOWN, 32'd0);
		offer(it);
		it = blank(MODE_LOCAL, 32'd0);
		it.sched_lateness = 16'sd64;
		it.queue_delay = 16'h8000;
		offer(it);
		it = blank(MODE_NET, 32'd0);
		it.loss_q16 = 16'hFFFF;
		it.nack_count = 16'hFFFF;
		it.rtt_present = 1'b1;
		it.rtt_ms = 16'hFFFF;
		it.rr_present = 1'b1;
		offer(it);
		it = blank(MODE_TAKE, 32'd10);
		offer(it);
		it = blank(MODE_NET, 32'd500);
		it.loss_q16 = LOSS_MODERATE;
		offer(it);
		it = blank(MODE_NET, 32'd1000);
		it.loss_q16 = LOSS_MODERATE;
		offer(it);
		it = blank(MODE_NET, 32'd2000);
		it.nack_count = NACK_LIMIT;
		offer(it);
		it = blank(MODE_LOCAL, 32'd3000);
		it.dropped_total = 32'd5;
		offer(it);
		it = blank(MODE_LOCAL, 32'd4000);
		it.dropped_total = 32'd5;
		it.queue_delay = 16'sd1600;
		offer(it);
		it = blank(MODE_TAKE, 32'd4001);
		offer(it);
		it = blank(MODE_NET, 32'd4100);
		it.rtt_present = 1'b1;
		it.rtt_ms = 16'd100;
		offer(it);
		it = blank(MODE_NET, 32'd5000);
		it.rtt_present = 1'b1;
		it.rtt_ms = 16'd200;
		offer(it);
		it = blank(MODE_LOCAL, 32'd5100);
		it.dropped_total = 32'd5;
		it.sched_lateness = 16'sd32;
		offer(it);
		it = blank(MODE_LOCAL, 32'd5200);
		it.dropped_total = 32'd5;
		it.sched_lateness = 16'sh7FFF;
		it.queue_delay = 16'sh7FFF;
		offer(it);
		it = blank(MODE_TAKE, 32'd5300);
		offer(it);
		for (int k = 0; k < 3; k++) begin
			it = blank(MODE_NET, 32'd8100 + 32'(k) * 32'd100);
			it.rr_present = 1'b1;
			offer(it);
		end
		it = blank(MODE_TAKE, 32'd8400);
		offer(it);
		it = blank(MODE_TAKE, 32'd8500);
		offer(it);
		it = blank(MODE_NET, 32'hFFFF_FFFF);
		it.loss_q16 = LOSS_SEVERE;
		offer(it);
		it = blank(MODE_NET, 32'h0000_0100);
		it.loss_q16 = LOSS_SEVERE - 16'd1;
		it.nack_count = NACK_LIMIT - 16'd1;
		it.rr_present = 1'b1;
		offer(it);
		it = blank(MODE_LOCAL, 32'h0000_0200);
		it.dropped_total = 32'd5;
		it.sched_lateness = 16'sh8000;
		it.queue_delay = 16'shFFFF;
		offer(it);
		it = blank(MODE_TAKE, 32'h0000_0300);
		offer(it);

		ms_now = 32'd6000;
		drops_base = 32'd5;
		for (int ph = 0; ph < CAP_PHASES; ph++) begin
			case (ph)
				0: cap = 30'd1000000000;
				1: cap = 30'd1;
				2: cap = 30'd0;
				3: cap = 30'd5000000;
				4: cap = 30'd9000000;
				5: cap = 30'd20000000;
				default: cap = 30'($urandom_range(1, 1000000000));
			endcase
			load_max_rate(cap);
			for (int n = 0; n < RANDOM_ITEMS / CAP_PHASES; n++) begin
				idx = ph * (RANDOM_ITEMS / CAP_PHASES) + n;
				if (idx == RANDOM_ITEMS / 3) begin
					send_idle_pct = 85;
					recv_idle_pct = 20;
				end
				if (idx == 2 * RANDOM_ITEMS / 3) begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				if (idx == HOLD_AT)
					hold_req = 1'b1;
				roll_report(idx, it);
				offer(it);
			end
		end

		drain();
		if (mismatches == 0 && decisions_owed == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
